[rtl/core/tcpq_pkg.sv]
// tcpq_pkg: shared constants, codes and controller/datapath types for the
// two-class priority multi-queue. No dependencies.
package tcpq_pkg;

  localparam int NUM_COUNTERS = 8;
  localparam int QUEUE_DEPTH  = 16;

  // Field widths of the words on the channels.
  localparam int CMD_W   = 2;
  localparam int NLO_W   = 64;
  localparam int NHI_W   = 56;
  localparam int CLS_W   = 2;
  localparam int CNUM_W  = 4;
  localparam int STAT_W  = 3;
  localparam int TAG_W   = NLO_W + NHI_W;

  // Effective active count, wide enough to hold NUM_COUNTERS itself.
  localparam int ACT_W   = 5;
  localparam logic [CNUM_W-1:0] ACT_RESET = 4'd8;

  localparam int CIDX_W  = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = CIDX_W + 1 + PTR_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;

  localparam logic [CLS_W-1:0] CLS_NORMAL  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SPECIAL = 2'd1;

  localparam logic [STAT_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_SERVED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_SHOWN    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request word
    logic do_enq;    // perform the enqueue of the captured word
    logic do_visit;  // visit the current counter of a round
  } tcpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic advance;   // the result pipeline can take a new entry
    logic at_last;   // the current counter is the last active one
  } tcpq_stat_t;

endpackage

[rtl/core/tcpq_req_if.sv]
// tcpq_req_if: request channel (valid/ready plus the request word fields).
// Depends on tcpq_pkg.
interface tcpq_req_if;
  logic                        valid;
  logic                        ready;
  logic [tcpq_pkg::CMD_W-1:0]  cmd;
  logic [tcpq_pkg::NLO_W-1:0]  name_low;
  logic [tcpq_pkg::NHI_W-1:0]  name_high;
  logic [tcpq_pkg::CLS_W-1:0]  priority_class;
  logic [tcpq_pkg::CNUM_W-1:0] service_number;

  modport source (output valid, cmd, name_low, name_high, priority_class, service_number,
                  input ready);
  modport sink (input valid, cmd, name_low, name_high, priority_class, service_number,
                output ready);
endinterface

[rtl/core/tcpq_rsp_if.sv]
// tcpq_rsp_if: response channel (valid/ready plus the result word fields).
// Depends on tcpq_pkg.
interface tcpq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tcpq_pkg::STAT_W-1:0] status;
  logic [tcpq_pkg::CNUM_W-1:0] counter_number;
  logic [tcpq_pkg::NLO_W-1:0]  tag_low;
  logic [tcpq_pkg::NHI_W-1:0]  tag_high;
  logic                        from_special;
  logic                        last;

  modport source (output valid, status, counter_number, tag_low, tag_high, from_special,
                  last, input ready);
  modport sink (input valid, status, counter_number, tag_low, tag_high, from_special,
                last, output ready);
endinterface

[rtl/core/tcpq_cfg_if.sv]
// tcpq_cfg_if: configuration write channel for the active counter count.
// Depends on tcpq_pkg.
interface tcpq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcpq_pkg::CNUM_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/core/two_class_priority_multiqueue.sv]
// Two-class strict-priority multi-queue: an enqueue passes from the accepted request
// word through the pending entry to the result register; serve and peek rounds visit
// one active counter per cycle while the result pipeline can advance. A new request is
// accepted only when the block is idle, after the enqueue or the whole round is done.
// Reset (synchronous, rst high) empties all queues and sets the active count to 8;
// the tag memory itself is not cleared.
module two_class_priority_multiqueue (
  input  logic       clk,
  input  logic       rst,
  tcpq_req_if.sink   request,
  tcpq_rsp_if.source response,
  tcpq_cfg_if.sink   cfg
);

  // Controller and datapath talk only through these two structs.
  tcpq_pkg::tcpq_cmd_t  cmd;
  tcpq_pkg::tcpq_stat_t stat;

  // Active count takes any write unchecked; the user must write it only while idle.
  assign cfg.ready = 1'b1;

  // The controller owns the request handshake and steps through each round;
  // the datapath holds the queue records, the tag memory and the result words.
  tcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_cmd   (request.cmd),
    .req_ready (request.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Results flow through a pending stage (which waits on the tag memory read)
  // and an output register, so a word waiting at the output does not hold off
  // the next visit more than one entry deep.
  tcpq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_cmd       (request.cmd),
    .req_name_low  (request.name_low),
    .req_name_high (request.name_high),
    .req_class     (request.priority_class),
    .req_service   (request.service_number),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.data),
    .rsp_valid     (response.valid),
    .rsp_ready     (response.ready),
    .rsp_status    (response.status),
    .rsp_counter   (response.counter_number),
    .rsp_tag_low   (response.tag_low),
    .rsp_tag_high  (response.tag_high),
    .rsp_special   (response.from_special),
    .rsp_last      (response.last)
  );

endmodule

[rtl/core/tcpq_ram.sv]
// tcpq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/tcpq_ctrl.sv]
// tcpq_ctrl: sequencing state machine for enqueue and serve/peek rounds.
// Depends on tcpq_pkg.
module tcpq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [tcpq_pkg::CMD_W-1:0] req_cmd,
  output logic                       req_ready,
  input  tcpq_pkg::tcpq_stat_t       stat,
  output tcpq_pkg::tcpq_cmd_t        cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENQ  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.do_enq   = 1'b0;
    cmd.do_visit = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          unique case (req_cmd) inside
            tcpq_pkg::CMD_ENQ:                       state_next = S_ENQ;
            tcpq_pkg::CMD_SERVE, tcpq_pkg::CMD_PEEK: state_next = S_RUN;
            default:                                 state_next = S_IDLE;
          endcase
        end
      end
      S_ENQ: begin
        if (stat.advance) begin
          cmd.do_enq = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        if (stat.advance) begin
          cmd.do_visit = 1'b1;
          if (stat.at_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/tcpq_datapath.sv]
// tcpq_datapath: queue pointers, tag memory, active count register and the
// two-entry result pipeline. Depends on tcpq_pkg and tcpq_ram.
module tcpq_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tcpq_pkg::tcpq_cmd_t         cmd,
  output tcpq_pkg::tcpq_stat_t        stat,
  // request word
  input  logic [tcpq_pkg::CMD_W-1:0]  req_cmd,
  input  logic [tcpq_pkg::NLO_W-1:0]  req_name_low,
  input  logic [tcpq_pkg::NHI_W-1:0]  req_name_high,
  input  logic [tcpq_pkg::CLS_W-1:0]  req_class,
  input  logic [tcpq_pkg::CNUM_W-1:0] req_service,
  // configuration write
  input  logic                        cfg_we,
  input  logic [tcpq_pkg::CNUM_W-1:0] cfg_data,
  // result word
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [tcpq_pkg::STAT_W-1:0] rsp_status,
  output logic [tcpq_pkg::CNUM_W-1:0] rsp_counter,
  output logic [tcpq_pkg::NLO_W-1:0]  rsp_tag_low,
  output logic [tcpq_pkg::NHI_W-1:0]  rsp_tag_high,
  output logic                        rsp_special,
  output logic                        rsp_last
);

  localparam int NC = tcpq_pkg::NUM_COUNTERS;
  localparam int CW = tcpq_pkg::CIDX_W;
  localparam int PW = tcpq_pkg::PTR_W;
  localparam int FW = tcpq_pkg::FILL_W;
  localparam int AW = tcpq_pkg::ACT_W;

  // Captured request word.
  logic [tcpq_pkg::CMD_W-1:0]  op;
  logic [tcpq_pkg::NLO_W-1:0]  name_low;
  logic [tcpq_pkg::NHI_W-1:0]  name_high;
  logic [tcpq_pkg::CLS_W-1:0]  cls;
  logic [tcpq_pkg::CNUM_W-1:0] svc;

  logic [tcpq_pkg::CNUM_W-1:0] act_reg;
  logic [AW-1:0]               act_eff;
  logic [CW-1:0]               ctr;

  // Per-counter queue records, special and normal class side by side.
  logic [FW-1:0] fill_s [NC];
  logic [FW-1:0] fill_n [NC];
  logic [PW-1:0] head_s [NC];
  logic [PW-1:0] head_n [NC];
  logic [PW-1:0] tail_s [NC];
  logic [PW-1:0] tail_n [NC];

  // Result pipeline: pending entry, then output register.
  logic                        p_valid;
  logic [tcpq_pkg::STAT_W-1:0] p_status;
  logic [tcpq_pkg::CNUM_W-1:0] p_counter;
  logic                        p_special;
  logic                        p_last;
  logic                        p_tag;

  logic out_free;
  logic advance;

  // Enqueue decode.
  logic [tcpq_pkg::CNUM_W-1:0] svc_m1;
  logic [CW-1:0]               eidx;
  logic                        ctr_ok;
  logic [FW-1:0]               efill;
  logic [PW-1:0]               etail;
  logic                        enq_ok;

  // Visit decode.
  logic          vs;
  logic          vn;
  logic          has;
  logic          is_serve;
  logic          later;
  logic [NC-1:0] ne_above;
  logic [PW-1:0] vhead;

  logic                          ram_we;
  logic [tcpq_pkg::ADDR_W-1:0]   ram_waddr;
  logic [tcpq_pkg::ADDR_W-1:0]   ram_raddr;
  logic                          ram_re;
  logic [tcpq_pkg::TAG_W-1:0]    ram_rdata;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(tcpq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Active count: zero counts as one, anything above the counter count saturates.
  always_comb begin
    if (act_reg == '0) begin
      act_eff = AW'(1);
    end else if ({1'b0, act_reg} > AW'(NC)) begin
      act_eff = AW'(NC);
    end else begin
      act_eff = {1'b0, act_reg};
    end
  end

  always_comb begin
    svc_m1 = svc - 1'b1;
    eidx   = svc_m1[CW-1:0];
    ctr_ok = (svc != '0) && ({1'b0, svc} <= act_eff);
    efill  = cls[0] ? fill_s[eidx] : fill_n[eidx];
    etail  = cls[0] ? tail_s[eidx] : tail_n[eidx];
    enq_ok = ctr_ok && (cls == tcpq_pkg::CLS_NORMAL || cls == tcpq_pkg::CLS_SPECIAL) &&
             (efill != FW'(tcpq_pkg::QUEUE_DEPTH));
  end

  always_comb begin
    vs       = (fill_s[ctr] != '0);
    vn       = (fill_n[ctr] != '0);
    has      = vs || vn;
    vhead    = vs ? head_s[ctr] : head_n[ctr];
    is_serve = (op == tcpq_pkg::CMD_SERVE);
    for (int k = 0; k < NC; k++) begin
      ne_above[k] = ((fill_s[k] != '0) || (fill_n[k] != '0)) &&
                    (AW'(k) < act_eff) && (CW'(k) > ctr);
    end
    later = |ne_above;
  end

  assign out_free     = !rsp_valid || rsp_ready;
  assign advance      = !p_valid || out_free;
  assign stat.advance = advance;
  assign stat.at_last = ((AW'(ctr) + AW'(1)) == act_eff);

  assign ram_we    = cmd.do_enq && enq_ok;
  assign ram_waddr = {eidx, cls[0], etail};
  assign ram_re    = cmd.do_visit && has;
  assign ram_raddr = {ctr, vs, vhead};

  tcpq_ram #(
    .WIDTH (tcpq_pkg::TAG_W),
    .DEPTH (tcpq_pkg::RAM_DEPTH)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({name_high, name_low}),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= req_cmd;
      name_low  <= req_name_low;
      name_high <= req_name_high;
      cls       <= req_class;
      svc       <= req_service;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_reg <= tcpq_pkg::ACT_RESET;
    end else if (cfg_we) begin
      act_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
    end else if (cmd.load) begin
      ctr <= '0;
    end else if (cmd.do_visit) begin
      ctr <= ctr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NC; k++) begin
        fill_s[k] <= '0;
        fill_n[k] <= '0;
        head_s[k] <= '0;
        head_n[k] <= '0;
        tail_s[k] <= '0;
        tail_n[k] <= '0;
      end
    end else begin
      if (cmd.do_enq && enq_ok) begin
        if (cls[0]) begin
          tail_s[eidx] <= ptr_inc(etail);
          fill_s[eidx] <= efill + 1'b1;
        end else begin
          tail_n[eidx] <= ptr_inc(etail);
          fill_n[eidx] <= efill + 1'b1;
        end
      end
      if (cmd.do_visit && is_serve && has) begin
        if (vs) begin
          head_s[ctr] <= ptr_inc(vhead);
          fill_s[ctr] <= fill_s[ctr] - 1'b1;
        end else begin
          head_n[ctr] <= ptr_inc(vhead);
          fill_n[ctr] <= fill_n[ctr] - 1'b1;
        end
      end
    end
  end

  // Pending entry: loaded by an enqueue or by a visit that yields a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (advance) begin
      p_valid <= cmd.do_enq || (cmd.do_visit && (is_serve || has));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (cmd.do_enq) begin
        p_status  <= enq_ok ? tcpq_pkg::ST_ENQUEUED : tcpq_pkg::ST_REJECTED;
        p_counter <= ctr_ok ? svc : '0;
        p_special <= enq_ok && cls[0];
        p_last    <= 1'b1;
        p_tag     <= 1'b0;
      end else begin
        if (!is_serve) begin
          p_status <= tcpq_pkg::ST_SHOWN;
        end else if (has) begin
          p_status <= tcpq_pkg::ST_SERVED;
        end else begin
          p_status <= tcpq_pkg::ST_EMPTY;
        end
        p_counter <= tcpq_pkg::CNUM_W'(AW'(ctr) + AW'(1));
        p_special <= has && vs;
        p_last    <= is_serve ? stat.at_last : !later;
        p_tag     <= has;
      end
    end
  end

  // Output register; the tag comes from the RAM read issued with the visit.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p_valid) begin
      rsp_status   <= p_status;
      rsp_counter  <= p_counter;
      rsp_special  <= p_special;
      rsp_last     <= p_last;
      rsp_tag_low  <= p_tag ? ram_rdata[tcpq_pkg::NLO_W-1:0] : '0;
      rsp_tag_high <= p_tag ? ram_rdata[tcpq_pkg::TAG_W-1:tcpq_pkg::NLO_W] : '0;
    end
  end

endmodule
